[rtl/hmn_pkg.sv]
// Shared types and constants for the height map to normal map block.
`default_nettype none
package hmn_pkg;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_W = 16;
    localparam int MAP_WIDTH_W = 11;
    localparam int GAIN_W = 16;
    localparam logic [MAP_WIDTH_W-1:0] MAP_WIDTH_RST = 11'd256;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd4096;
    localparam logic REG_MAP_WIDTH = 1'b0;
    localparam logic REG_HEIGHT_GAIN = 1'b1;
    localparam logic ACT_FLUSH = 1'b1;

    // neighbourhood of one pixel, handed from front to back
    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] down;
        logic [7:0] up;
        logic       last;
    } hmn_req_t;
endpackage
`default_nettype wire

[rtl/hmn_queue.sv]
// Small FIFO between the front and back parts.
`default_nettype none
module hmn_queue #(
    parameter int DEPTH = hmn_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire hmn_pkg::hmn_req_t push_data,
    output logic                  full,
    input  wire logic             pop,
    output hmn_pkg::hmn_req_t     pop_data,
    output logic                  not_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hmn_pkg::hmn_req_t entry_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] count_reg;

    assign full = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data = entry_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH)) else $error("queue over depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0) else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow");
endmodule
`default_nettype wire

[rtl/hmn_front.sv]
// Front part: accepts samples, owns the line stores, gathers neighbours.
`default_nettype none
module hmn_front #(
    parameter int MAX_WIDTH = hmn_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire logic                           action,
    input  wire logic [7:0]                     height_sample,
    input  wire logic [hmn_pkg::MAP_WIDTH_W-1:0] map_width,
    output logic                                push,
    output hmn_pkg::hmn_req_t                   push_data,
    input  wire logic                           q_full
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int EW = (XW + 1 > hmn_pkg::MAP_WIDTH_W) ? XW + 1 : hmn_pkg::MAP_WIDTH_W;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_EMIT = 2'b10
    } fstate_t;

    fstate_t st_reg;
    logic [XW-1:0] col_reg;
    logic [1:0] rows_reg;
    logic [7:0] left_reg;
    logic flush_reg;
    logic [7:0] samp_reg;
    logic [7:0] c_rd_reg, r_rd_reg, d_rd_reg;
    logic [7:0] above_mem [MAX_WIDTH];
    logic [7:0] two_mem [MAX_WIDTH];

    logic [EW-1:0] eff_w, mw_ext, xp1_ext;
    logic [XW-1:0] xp1;
    logic accept, take, row_end, has_res, go;

    assign sample_stall = (st_reg != F_IDLE);
    assign accept = sample_valid && !sample_stall;
    // flush with no complete row is dropped
    assign take = accept && !(action == hmn_pkg::ACT_FLUSH && rows_reg == 2'd0);

    assign mw_ext = EW'(map_width);
    always_comb
    begin
        priority if (map_width == '0)
            eff_w = EW'(1);
        else if (mw_ext > EW'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = mw_ext;
    end

    assign xp1 = col_reg + 1'b1;
    assign xp1_ext = EW'(col_reg) + 1'b1;
    assign row_end = !(xp1_ext < eff_w);
    assign has_res = (rows_reg != 2'd0);
    assign go = (st_reg == F_EMIT) && (!has_res || !q_full);
    assign push = go && has_res;

    always_comb
    begin
        push_data.left = (col_reg != '0) ? left_reg : 8'd0;
        push_data.right = row_end ? 8'd0 : r_rd_reg;
        push_data.down = (rows_reg == 2'd2) ? d_rd_reg : 8'd0;
        push_data.up = flush_reg ? 8'd0 : samp_reg;
        push_data.last = flush_reg && row_end;
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == F_IDLE)
        begin
            c_rd_reg <= above_mem[col_reg];
            r_rd_reg <= above_mem[xp1];
        end
        if (go && !flush_reg)
        begin
            above_mem[col_reg] <= samp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == F_IDLE)
        begin
            d_rd_reg <= two_mem[col_reg];
        end
        if (go && !flush_reg)
        begin
            two_mem[col_reg] <= c_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            flush_reg <= action;
            samp_reg <= height_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= F_IDLE;
            col_reg <= '0;
            rows_reg <= 2'd0;
            left_reg <= 8'd0;
        end
        else
        begin
            unique case (st_reg)
                F_IDLE:
                begin
                    if (take)
                    begin
                        st_reg <= F_EMIT;
                    end
                end
                F_EMIT:
                begin
                    if (go)
                    begin
                        st_reg <= F_IDLE;
                        left_reg <= c_rd_reg;
                        if (row_end)
                        begin
                            col_reg <= '0;
                            if (flush_reg)
                                rows_reg <= 2'd0;
                            else if (rows_reg != 2'd2)
                                rows_reg <= rows_reg + 1'b1;
                        end
                        else
                        begin
                            col_reg <= xp1;
                        end
                    end
                end
                default:
                begin
                    st_reg <= F_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/hmn_back.sv]
// Back part: gain multiply, integer square root and normalizing divides.
`default_nettype none
module hmn_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [hmn_pkg::GAIN_W-1:0] height_gain,
    input  wire logic                      q_not_empty,
    input  wire hmn_pkg::hmn_req_t         q_data,
    output logic                           pop,
    output logic                           normal_valid,
    input  wire logic                      normal_stall,
    output logic signed [15:0]             normal_x,
    output logic [14:0]                    normal_y,
    output logic signed [15:0]             normal_z,
    output logic                           frame_last
);
    typedef enum logic [8:0] {
        B_IDLE  = 9'b000000001,
        B_MULX  = 9'b000000010,
        B_MULZ  = 9'b000000100,
        B_SQX   = 9'b000001000,
        B_SQZ   = 9'b000010000,
        B_SQRT  = 9'b000100000,
        B_DLOAD = 9'b001000000,
        B_DIV   = 9'b010000000,
        B_OUT   = 9'b100000000
    } bstate_t;

    localparam logic [49:0] Y_SQ = 50'd67108864;   // 8192^2
    localparam logic [23:0] Y_MAG = 24'd8192;

    bstate_t st_reg;
    logic nx_reg, nz_reg, last_reg;
    logic [7:0] dx_reg, dz_reg;
    logic [23:0] ax_reg, az_reg;
    logic [49:0] sum_reg;
    logic [25:0] rem_reg;
    logic [24:0] root_reg;
    logic [4:0] cnt_reg;
    logic [1:0] comp_reg;
    logic [24:0] drem_reg;
    logic [14:0] lo_reg, quo_reg;
    logic [14:0] qx_reg, qy_reg;

    logic [23:0] mul_a, mul_b;
    logic [47:0] prod;
    logic [27:0] t_rem, trial;
    logic sq_ge;
    logic [23:0] mag;
    logic [38:0] num;
    logic [25:0] t_div;
    logic div_ge;
    logic [14:0] quo_fin;
    logic out_free;

    assign pop = (st_reg == B_IDLE) && q_not_empty;
    assign out_free = !normal_valid || !normal_stall;

    always_comb
    begin
        unique case (st_reg)
            B_MULX:
            begin
                mul_a = 24'(dx_reg);
                mul_b = 24'(height_gain);
            end
            B_MULZ:
            begin
                mul_a = 24'(dz_reg);
                mul_b = 24'(height_gain);
            end
            B_SQX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            default:
            begin
                mul_a = az_reg;
                mul_b = az_reg;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // one result bit per step of the root, from two bits of the sum
    assign t_rem = {rem_reg, sum_reg[49:48]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign sq_ge = (t_rem >= trial);

    always_comb
    begin
        unique case (comp_reg)
            2'd0: mag = ax_reg;
            2'd1: mag = Y_MAG;
            default: mag = az_reg;
        endcase
    end
    assign num = {1'b0, mag, 14'd0} + 39'(root_reg[24:1]);
    // quotient never exceeds 16384, so it fits the low 15 steps
    assign t_div = {drem_reg, lo_reg[14]};
    assign div_ge = (t_div >= {1'b0, root_reg});
    assign quo_fin = {quo_reg[13:0], div_ge};

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            B_IDLE:
            begin
                nx_reg <= q_data.left < q_data.right;
                nz_reg <= q_data.down < q_data.up;
                dx_reg <= (q_data.left < q_data.right) ? q_data.right - q_data.left
                                                       : q_data.left - q_data.right;
                dz_reg <= (q_data.down < q_data.up) ? q_data.up - q_data.down
                                                    : q_data.down - q_data.up;
                last_reg <= q_data.last;
            end
            B_MULX: ax_reg <= prod[23:0];
            B_MULZ: az_reg <= prod[23:0];
            B_SQX: sum_reg <= 50'(prod) + Y_SQ;
            B_SQZ:
            begin
                sum_reg <= sum_reg + 50'(prod);
                rem_reg <= '0;
                root_reg <= '0;
                comp_reg <= 2'd0;
            end
            B_SQRT:
            begin
                sum_reg <= {sum_reg[47:0], 2'b00};
                rem_reg <= sq_ge ? 26'(t_rem - trial) : t_rem[25:0];
                root_reg <= {root_reg[23:0], sq_ge};
            end
            B_DLOAD:
            begin
                drem_reg <= {1'b0, num[38:15]};
                lo_reg <= num[14:0];
                quo_reg <= '0;
            end
            B_DIV:
            begin
                drem_reg <= div_ge ? 25'(t_div - {1'b0, root_reg}) : t_div[24:0];
                lo_reg <= {lo_reg[13:0], 1'b0};
                quo_reg <= quo_fin;
                if (cnt_reg == 5'd14)
                begin
                    comp_reg <= comp_reg + 1'b1;
                    if (comp_reg == 2'd0)
                        qx_reg <= quo_fin;
                    else if (comp_reg == 2'd1)
                        qy_reg <= quo_fin;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == B_OUT && out_free)
        begin
            normal_x <= nx_reg ? $signed(16'd0 - {1'b0, qx_reg}) : $signed({1'b0, qx_reg});
            normal_y <= qy_reg;
            normal_z <= nz_reg ? $signed(16'd0 - {1'b0, quo_reg}) : $signed({1'b0, quo_reg});
            frame_last <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE;
            cnt_reg <= '0;
            normal_valid <= 1'b0;
        end
        else
        begin
            if (st_reg == B_OUT && out_free)
            begin
                normal_valid <= 1'b1;
            end
            else if (normal_valid && !normal_stall)
            begin
                normal_valid <= 1'b0;
            end
            unique case (st_reg)
                B_IDLE: if (q_not_empty) st_reg <= B_MULX;
                B_MULX: st_reg <= B_MULZ;
                B_MULZ: st_reg <= B_SQX;
                B_SQX: st_reg <= B_SQZ;
                B_SQZ:
                begin
                    st_reg <= B_SQRT;
                    cnt_reg <= '0;
                end
                B_SQRT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd24)
                        st_reg <= B_DLOAD;
                end
                B_DLOAD:
                begin
                    st_reg <= B_DIV;
                    cnt_reg <= '0;
                end
                B_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd14)
                        st_reg <= (comp_reg == 2'd2) ? B_OUT : B_DLOAD;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        st_reg <= B_IDLE;
                    end
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/heightmap_normal_map.sv]
// Top level: configuration registers and the front, queue and back parts.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------------
//  sample    | sample_valid / sample_stall  | action, height_sample
//  normal    | normal_valid / normal_stall  | normal_x, normal_y, normal_z, frame_last
//  config    | cfg_write                    | cfg_index, cfg_data
//
// Front takes no new request until it has pushed the last one (line store read, then write/push).
// Back works on one result at a time: a pop, 4 multiply steps, 25 root steps,
// and 3 x (1 load + 15 steps) of a shared restoring divider, then the output register.
// A 2-entry queue and the output register let each side stall on its own.
// Reset: map_width 256, height_gain 4096, counters zero; line stores not cleared.
`default_nettype none
module heightmap_normal_map #(
    parameter int MAX_WIDTH = hmn_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     sample_valid,
    output logic                          sample_stall,
    input  wire logic                     action,
    input  wire logic [7:0]               height_sample,
    output logic                          normal_valid,
    input  wire logic                     normal_stall,
    output logic signed [15:0]            normal_x,
    output logic [14:0]                   normal_y,
    output logic signed [15:0]            normal_z,
    output logic                          frame_last,
    input  wire logic                     cfg_write,
    input  wire logic                     cfg_index,
    input  wire logic [hmn_pkg::CFG_W-1:0] cfg_data
);
    logic [hmn_pkg::MAP_WIDTH_W-1:0] map_width_reg;
    logic [hmn_pkg::GAIN_W-1:0] gain_reg;
    logic push, q_full, pop, q_not_empty;
    hmn_pkg::hmn_req_t push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg <= hmn_pkg::MAP_WIDTH_RST;
            gain_reg <= hmn_pkg::GAIN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hmn_pkg::REG_MAP_WIDTH:
                    map_width_reg <= cfg_data[hmn_pkg::MAP_WIDTH_W-1:0];
                hmn_pkg::REG_HEIGHT_GAIN:
                    gain_reg <= cfg_data[hmn_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    hmn_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .action(action),
        .height_sample(height_sample),
        .map_width(map_width_reg),
        .push(push),
        .push_data(push_data),
        .q_full(q_full)
    );

    hmn_queue #(.DEPTH(hmn_pkg::QUEUE_DEPTH)) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_data(push_data),
        .full(q_full),
        .pop(pop),
        .pop_data(pop_data),
        .not_empty(q_not_empty)
    );

    hmn_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .height_gain(gain_reg),
        .q_not_empty(q_not_empty),
        .q_data(pop_data),
        .pop(pop),
        .normal_valid(normal_valid),
        .normal_stall(normal_stall),
        .normal_x(normal_x),
        .normal_y(normal_y),
        .normal_z(normal_z),
        .frame_last(frame_last)
    );
endmodule
`default_nettype wire

[sim/hmn_checker.sv]
// Normal map checker: predicts each normal from accepted requests and compares results.
`timescale 1ns / 100ps
module hmn_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    input  logic        sample_stall,
    input  logic        action,
    input  logic [7:0]  height_sample,
    input  logic        normal_valid,
    input  logic        normal_stall,
    input  logic [15:0] normal_x,
    input  logic [14:0] normal_y,
    input  logic [15:0] normal_z,
    input  logic        frame_last,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [hmn_pkg::CFG_W-1:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);
    localparam int LINE_DEPTH = 1024;

    typedef struct packed {
        logic [15:0] x;
        logic [14:0] y;
        logic [15:0] z;
        logic        last;
    } normal_t;

    normal_t expected_normals[$];

    logic [hmn_pkg::MAP_WIDTH_W-1:0] width_reg;
    logic [hmn_pkg::GAIN_W-1:0]      gain_reg;
    logic [7:0]             line_above[LINE_DEPTH];
    logic [7:0]             line_two_above[LINE_DEPTH];
    int unsigned            col;
    int unsigned            rows_done;
    logic [7:0]             prev_center;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // rounded |c| / r in Q1.14, clipped at 1.0
    function automatic longint unsigned unit_mag(input longint unsigned mag,
                                                 input longint unsigned r);
        longint unsigned q;
        q = (mag * 16384 + (r >> 1)) / r;
        return (q > 16384) ? 16384 : q;
    endfunction

    function automatic normal_t surface_normal(input int unsigned l, input int unsigned rt,
                                               input int unsigned d, input int unsigned u,
                                               input logic last);
        normal_t n;
        bit neg_x, neg_z;
        longint unsigned ax, az, r, mx, mz;
        neg_x = l < rt;
        neg_z = d < u;
        ax = longint'(neg_x ? rt - l : l - rt) * gain_reg;
        az = longint'(neg_z ? u - d : d - u) * gain_reg;
        r = int_sqrt(ax * ax + az * az + 64'd8192 * 64'd8192);
        mx = unit_mag(ax, r);
        mz = unit_mag(az, r);
        n.x = neg_x ? 16'(0 - mx) : 16'(mx);
        n.y = 15'(unit_mag(8192, r));
        n.z = neg_z ? 16'(0 - mz) : 16'(mz);
        n.last = last;
        return n;
    endfunction

    task automatic take_request(input logic act, input logic [7:0] h);
        int unsigned w, x, left, right, down, up;
        logic [7:0] center;
        bit is_flush, row_end;
        w = (width_reg == 0) ? 1 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
        is_flush = (act == hmn_pkg::ACT_FLUSH);
        x = (col >= LINE_DEPTH) ? 0 : col;
        if (is_flush && rows_done == 0)
            return;
        center = line_above[x];
        left = (x > 0) ? prev_center : 0;
        right = (x + 1 < w) ? line_above[x + 1] : 0;
        down = (rows_done >= 2) ? line_two_above[x] : 0;
        up = is_flush ? 0 : h;
        row_end = (x + 1 >= w);
        if (rows_done >= 1)
            expected_normals.insert(expected_normals.size(),
                                    surface_normal(left, right, down, up,
                                                   is_flush && row_end));
        prev_center = center;
        if (!is_flush) begin
            line_two_above[x] = center;
            line_above[x] = h;
        end
        if (row_end) begin
            col = 0;
            if (is_flush)
                rows_done = 0;
            else if (rows_done < 2)
                rows_done++;
        end
        else
            col = x + 1;
    endtask

    always @(posedge clk or negedge rst_n) begin
        normal_t exp_n;
        normal_t got;
        if (!rst_n) begin
            width_reg = hmn_pkg::MAP_WIDTH_RST;
            gain_reg = hmn_pkg::GAIN_RST;
            col = 0;
            rows_done = 0;
            prev_center = 0;
            mismatches = 0;
            expected_normals.delete();
        end
        else begin
            if (cfg_write) begin
                if (cfg_index == hmn_pkg::REG_MAP_WIDTH)
                    width_reg = cfg_data[hmn_pkg::MAP_WIDTH_W-1:0];
                else
                    gain_reg = cfg_data[hmn_pkg::GAIN_W-1:0];
            end
            if (sample_valid && !sample_stall)
                take_request(action, height_sample);
            if (normal_valid && !normal_stall) begin
                got = '{normal_x, normal_y, normal_z, frame_last};
                if (expected_normals.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected normal: expected none, got x=%0d y=%0d z=%0d last=%0b",
                             $time, $signed(normal_x), normal_y, $signed(normal_z),
                             frame_last);
                end
                else begin
                    exp_n = expected_normals.pop_front();
                    if (got !== exp_n) begin
                        mismatches++;
                        $display({"%0t normal mismatch: expected x=%0d y=%0d z=%0d last=%0b,",
                                  " got x=%0d y=%0d z=%0d last=%0b"},
                                 $time, $signed(exp_n.x), exp_n.y, $signed(exp_n.z),
                                 exp_n.last,
                                 $signed(got.x), got.y, $signed(got.z), got.last);
                    end
                end
            end
        end
        outstanding = expected_normals.size();
    end
endmodule

[sim/heightmap_normal_map_tb.sv]
// Testbench top: clock, reset, request and config stimulus, and the verdict.
`timescale 1ns / 100ps
module heightmap_normal_map_tb;
    localparam logic ACT_SAMPLE = ~hmn_pkg::ACT_FLUSH;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_stall;
    logic action;
    logic [7:0] height_sample;
    logic normal_valid;
    logic normal_stall;
    logic signed [15:0] normal_x;
    logic [14:0] normal_y;
    logic signed [15:0] normal_z;
    logic frame_last;
    logic cfg_write;
    logic cfg_index;
    logic [hmn_pkg::CFG_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int unsigned cur_width;
    int sent;

    heightmap_normal_map uut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall),
        .action(action), .height_sample(height_sample),
        .normal_valid(normal_valid), .normal_stall(normal_stall),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .frame_last(frame_last),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    hmn_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall),
        .action(action), .height_sample(height_sample),
        .normal_valid(normal_valid), .normal_stall(normal_stall),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .frame_last(frame_last),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge clk)
        normal_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic send_request(input logic act, input logic [7:0] h);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        action <= act;
        height_sample <= h;
        do @(posedge clk); while (sample_stall);
        sent++;
    endtask

    // hold off new requests until every predicted normal has come out
    task automatic drain();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [hmn_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == hmn_pkg::REG_MAP_WIDTH)
            cur_width = (val[hmn_pkg::MAP_WIDTH_W-1:0] == 0) ? 1 :
                        (val[hmn_pkg::MAP_WIDTH_W-1:0] > 1024) ? 1024 :
                        val[hmn_pkg::MAP_WIDTH_W-1:0];
    endtask

    function automatic logic [7:0] pick_height();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // rows of samples, then one flush row; stray flushes when noisy
    task automatic send_frame(input int rows, input bit noisy);
        if (noisy && $urandom_range(3) == 0)
            send_request(hmn_pkg::ACT_FLUSH, 8'($urandom));
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cur_width; c++)
                if (noisy && r > 0 && c + 1 < cur_width && $urandom_range(9) == 0)
                    send_request(hmn_pkg::ACT_FLUSH, 8'($urandom));
                else
                    send_request(ACT_SAMPLE, pick_height());
        for (int c = 0; c < cur_width; c++)
            send_request(hmn_pkg::ACT_FLUSH, 8'($urandom));
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct, input int quota);
        send_idle_pct = tx_pct;
        recv_stall_pct = rx_pct;
        sent = 0;
        while (sent < quota) begin
            drain();
            write_reg(hmn_pkg::REG_MAP_WIDTH, hmn_pkg::CFG_W'($urandom_range(12, 1)));
            if ($urandom_range(1))
                write_reg(hmn_pkg::REG_HEIGHT_GAIN, hmn_pkg::CFG_W'($urandom));
            send_frame($urandom_range(4, 2), 1'b1);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        action = ACT_SAMPLE;
        height_sample = 8'd0;
        normal_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = hmn_pkg::REG_MAP_WIDTH;
        cfg_data = '0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_width = 256;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: stray flush, steep edges at full gain, then a one-column map
        write_reg(hmn_pkg::REG_MAP_WIDTH, hmn_pkg::CFG_W'(3));
        write_reg(hmn_pkg::REG_HEIGHT_GAIN, 16'hFFFF);
        send_request(hmn_pkg::ACT_FLUSH, 8'hFF);
        send_request(ACT_SAMPLE, 8'd0);
        send_request(ACT_SAMPLE, 8'd255);
        send_request(ACT_SAMPLE, 8'd0);
        send_request(ACT_SAMPLE, 8'd255);
        send_request(ACT_SAMPLE, 8'd0);
        send_request(ACT_SAMPLE, 8'd255);
        send_request(ACT_SAMPLE, 8'd0);
        send_request(hmn_pkg::ACT_FLUSH, 8'h00);
        send_request(ACT_SAMPLE, 8'd128);
        send_request(hmn_pkg::ACT_FLUSH, 8'h55);
        send_request(hmn_pkg::ACT_FLUSH, 8'hAA);
        send_request(hmn_pkg::ACT_FLUSH, 8'h00);
        drain();
        write_reg(hmn_pkg::REG_MAP_WIDTH, hmn_pkg::CFG_W'(0));
        write_reg(hmn_pkg::REG_HEIGHT_GAIN, hmn_pkg::CFG_W'(0));
        send_frame(3, 1'b0);
        drain();
        write_reg(hmn_pkg::REG_HEIGHT_GAIN, hmn_pkg::GAIN_RST);
        send_frame(2, 1'b0);

        random_phase(23, 86, 110);
        random_phase(86, 23, 110);
        random_phase(0, 0, 110);

        // upper config bits set: only the low 11 bits land in the width
        drain();
        write_reg(hmn_pkg::REG_MAP_WIDTH, 16'hF810);
        write_reg(hmn_pkg::REG_HEIGHT_GAIN, hmn_pkg::CFG_W'($urandom));
        send_frame(2, 1'b0);

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
